// File: rtl/maf_pkg.sv
package maf_pkg;

  // Largest window the ring can hold.
  localparam int MAX_DEPTH = 32;
  localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 21;
  localparam int DEPTH_W  = 6;

  // Divider step counter covers one quotient bit per step.
  localparam int DIV_CNT_W = $clog2(SUM_W);

  // Window depth after reset.
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(16);

  // Front-to-back handoff: the oldest queued sample and whether it is there.
  typedef struct packed {
    logic                       vld;
    logic signed [SAMPLE_W-1:0] sample;
  } maf_item_t;

  // Clamp a written depth into the range the ring supports.
  function automatic logic [DEPTH_W-1:0] eff_depth(input logic [DEPTH_W-1:0] d);
    logic [DEPTH_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DEPTH_W'(1);
    end else if (int'(d) > MAX_DEPTH) begin
      r = DEPTH_W'(MAX_DEPTH);
    end
    return r;
  endfunction

endpackage

// File: rtl/moving_average_filter.sv
// Moving average over the last window_depth signed 16-bit samples. Each item
// pushed yields one result: the window sum and that sum divided by the depth,
// truncated toward zero. The ring and sum start at zero, so the first pass
// averages in zeros; a depth write (1 to 32, 0 reads as 1, larger values as
// 32) also clears the window at once, with no clearing pass. In the back end an
// item passes through reading the oldest ring entry, updating the sum and ring,
// the bit-serial divider (one quotient bit a cycle) and loading the result
// register; a new item is taken only once the last one is through. A two-entry
// input queue and the result register let both sides stall independently. Write
// the depth only while the block is idle.
module moving_average_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic signed [maf_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                full,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [maf_pkg::SAMPLE_W-1:0] out_average,
  output logic signed [maf_pkg::SUM_W-1:0]    out_window_sum,
  input  logic                                cfg_wr_en,
  input  logic [maf_pkg::DEPTH_W-1:0]         cfg_wr_data
);

  maf_pkg::maf_item_t item;
  logic               item_pop;

  // Front end: accepts and queues samples.
  maf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_sample(in_sample),
    .full     (full),
    .item     (item),
    .item_pop (item_pop)
  );

  // Back end: window update, division and result register.
  maf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .item          (item),
    .item_pop      (item_pop),
    .empty         (empty),
    .pop           (pop),
    .out_average   (out_average),
    .out_window_sum(out_window_sum)
  );

endmodule

// File: rtl/maf_front.sv
module maf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic signed [maf_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                full,
  output maf_pkg::maf_item_t                  item,
  input  logic                                item_pop
);

  // Two-entry queue of samples waiting for the back end.
  logic signed [maf_pkg::SAMPLE_W-1:0] slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign full     = (cnt_r == 2'd2);
  assign do_push  = push && !full;
  assign do_pop   = item_pop && (cnt_r != 2'd0);

  // The oldest entry is offered to the back end.
  assign item.vld    = (cnt_r != 2'd0);
  assign item.sample = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Sample storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= in_sample;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("front queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> (cnt_r != 2'd0))
    else $error("back end popped an empty front queue");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !item_pop) |=> (cnt_r == 2'd2))
    else $error("front queue lost or gained an item while full");
`endif

endmodule

// File: rtl/maf_back.sv
module maf_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [maf_pkg::DEPTH_W-1:0]          cfg_wr_data,
  input  maf_pkg::maf_item_t                   item,
  output logic                                 item_pop,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [maf_pkg::SAMPLE_W-1:0]  out_average,
  output logic signed [maf_pkg::SUM_W-1:0]     out_window_sum
);

  localparam int SAMPLE_W = maf_pkg::SAMPLE_W;
  localparam int SUM_W    = maf_pkg::SUM_W;
  localparam int DEPTH_W  = maf_pkg::DEPTH_W;
  localparam int IDX_W    = maf_pkg::IDX_W;
  localparam int CNT_W    = maf_pkg::DIV_CNT_W;

  // Saturation limits of the average, as quotient magnitudes.
  localparam logic [SUM_W-1:0] POS_LIMIT = SUM_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic [SUM_W-1:0] NEG_LIMIT = SUM_W'(2 ** (SAMPLE_W - 1));

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADD  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Window state.
  logic signed [SAMPLE_W-1:0] ring_mem [maf_pkg::MAX_DEPTH];
  logic [maf_pkg::MAX_DEPTH-1:0] ring_vld_r, ring_vld_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;

  // Item in flight.
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] old_data_r;
  logic                       old_vld_r;
  logic mem_re;
  logic mem_we;

  // Divider.
  logic [SUM_W-1:0]   dq_r, dq_nxt;
  logic [DEPTH_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic               neg_r, neg_nxt;

  // Result register.
  logic                       out_vld_r, out_vld_nxt;
  logic signed [SAMPLE_W-1:0] out_avg_r, out_avg_nxt;
  logic signed [SUM_W-1:0]    out_sum_r, out_sum_nxt;

  // Helpers.
  logic signed [SAMPLE_W-1:0] old_val;
  logic signed [SUM_W-1:0]    add_sum;
  logic [SUM_W-1:0]           add_mag;
  logic [IDX_W:0]             pos_inc;
  logic [DEPTH_W:0]           rem_sh;
  logic                       rem_ge;
  logic                       load_out;

  assign empty          = !out_vld_r;
  assign out_average    = out_avg_r;
  assign out_window_sum = out_sum_r;

  // Take a new sample only when idle; its ring entry is read the same cycle.
  assign mem_re   = (state_r == ST_IDLE) && item.vld;
  assign item_pop = mem_re;
  assign mem_we   = (state_r == ST_ADD);

  // New running sum: drop the oldest entry, add the new sample.
  assign old_val = old_vld_r ? old_data_r : '0;
  assign add_sum = sum_r
                 - {{(SUM_W - SAMPLE_W){old_val[SAMPLE_W-1]}}, old_val}
                 + {{(SUM_W - SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
  assign add_mag = add_sum[SUM_W-1] ? (~add_sum + SUM_W'(1)) : add_sum;
  assign pos_inc = {1'b0, pos_r} + (IDX_W + 1)'(1);

  // One restoring division step on the magnitude.
  assign rem_sh = {rem_r, dq_r[SUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, depth_r});

  // The result register is free, or is being emptied this cycle.
  assign load_out = (state_r == ST_DONE) && (!out_vld_r || pop);

  always_comb begin
    state_nxt    = state_r;
    ring_vld_nxt = ring_vld_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    depth_nxt    = depth_r;
    dq_nxt       = dq_r;
    rem_nxt      = rem_r;
    div_cnt_nxt  = div_cnt_r;
    neg_nxt      = neg_r;
    out_vld_nxt  = out_vld_r;
    out_avg_nxt  = out_avg_r;
    out_sum_nxt  = out_sum_r;

    if (pop && out_vld_r) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (item.vld) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        sum_nxt               = add_sum;
        ring_vld_nxt[pos_r]   = 1'b1;
        if (int'(pos_inc) >= int'(depth_r)) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_inc[IDX_W-1:0];
        end
        dq_nxt      = add_mag;
        neg_nxt     = add_sum[SUM_W-1];
        rem_nxt     = '0;
        div_cnt_nxt = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        dq_nxt  = {dq_r[SUM_W-2:0], rem_ge};
        rem_nxt = rem_ge ? DEPTH_W'(rem_sh - {1'b0, depth_r}) : rem_sh[DEPTH_W-1:0];
        div_cnt_nxt = div_cnt_r + CNT_W'(1);
        if (div_cnt_r == CNT_W'(SUM_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_vld_nxt = 1'b1;
          out_sum_nxt = sum_r;
          if (!neg_r) begin
            out_avg_nxt = (dq_r > POS_LIMIT) ? POS_LIMIT[SAMPLE_W-1:0] : dq_r[SAMPLE_W-1:0];
          end else if (dq_r > NEG_LIMIT) begin
            out_avg_nxt = NEG_LIMIT[SAMPLE_W-1:0];
          end else begin
            out_avg_nxt = SAMPLE_W'(~dq_r + SUM_W'(1));
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A depth write restarts the window; the user must write it only while idle, as the block does not enforce it.
    if (cfg_wr_en) begin
      depth_nxt    = maf_pkg::eff_depth(cfg_wr_data);
      ring_vld_nxt = '0;
      sum_nxt      = '0;
      pos_nxt      = '0;
    end
  end

  // Control state and window bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ring_vld_r <= '0;
      pos_r      <= '0;
      sum_r      <= '0;
      depth_r    <= maf_pkg::eff_depth(maf_pkg::DEPTH_RESET);
      div_cnt_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ring_vld_r <= ring_vld_nxt;
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      depth_r    <= depth_nxt;
      div_cnt_r  <= div_cnt_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    neg_r     <= neg_nxt;
    out_avg_r <= out_avg_nxt;
    out_sum_r <= out_sum_nxt;
    if (mem_re) begin
      sample_r  <= item.sample;
      old_vld_r <= ring_vld_r[pos_r];
    end
  end

  // Sample ring: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[pos_r] <= sample_r;
    end
    if (mem_re) begin
      old_data_r <= ring_mem[pos_r];
    end
  end

`ifndef NO_ASSERTIONS
  a_add_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD) |=> (state_r == ST_DIV))
    else $error("sum update not followed by division");

  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (int'(div_cnt_r) < SUM_W))
    else $error("divider step count overran");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < depth_r))
    else $error("divider remainder not below depth");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pos_r) < int'(depth_r))
    else $error("write position beyond window depth");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !pop) |=> (out_vld_r && $stable(out_sum_r)))
    else $error("waiting result dropped or changed");
`endif

endmodule
